>>> hw/rtl/sorted_stream_merge_top_defines.svh
// Assertion macros for the sorted stream merge checker.
// Used by ssm_checker.sv; no other dependencies.
`ifndef SORTED_STREAM_MERGE_TOP_DEFINES_SVH
`define SORTED_STREAM_MERGE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssm assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssm assertion failed");

`endif

>>> hw/rtl/ssm_pkg.sv
// Shared types and codes for the sorted stream merge block.
// No dependencies.
package ssm_pkg;

    localparam logic [1:0] CMD_FIRST      = 2'd0;
    localparam logic [1:0] CMD_SECOND     = 2'd1;
    localparam logic [1:0] CMD_END_FIRST  = 2'd2;
    localparam logic [1:0] CMD_END_SECOND = 2'd3;

    localparam logic [1:0] KIND_ELEM = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    localparam logic SIDE_FIRST  = 1'b0;
    localparam logic SIDE_SECOND = 1'b1;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic is_end;
        logic side;
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMP_RD,
        ST_CMP,
        ST_TAIL,
        ST_FLUSH_RD,
        ST_FLUSH,
        ST_FINAL
    } state_t;

endpackage

>>> hw/rtl/ssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/ssm_front.sv
// Front part: accepts input items, decodes cmd and queues them for the back part.
// Depends on ssm_pkg.
module ssm_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          q_valid,
    output ssm_pkg::cls_t                 q_cls,
    output logic signed [VALUE_WIDTH-1:0] q_value,
    input  logic                          q_pop
);

    import ssm_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    cls_t                          cls_mem [QDEPTH];
    logic signed [VALUE_WIDTH-1:0] val_mem [QDEPTH];
    logic [QAW-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]                  cnt_reg, cnt_next;
    cls_t                          cls_in;
    logic                          push;

    always_comb
    begin
        cls_in.is_end = cmd inside {CMD_END_FIRST, CMD_END_SECOND};
        cls_in.side   = cmd inside {CMD_SECOND, CMD_END_SECOND};
    end

    assign in_stall = (cnt_reg == (QAW+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_cls    = cls_mem[rd_ptr_reg];
    assign q_value  = val_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_mem[wr_ptr_reg] <= cls_in;
            val_mem[wr_ptr_reg] <= value;
        end
    end

endmodule

>>> hw/rtl/ssm_back.sv
// Back part: merge sequencer over the pending buffer, with the output register.
// Depends on ssm_pkg and ssm_ram.
module ssm_back #(
    parameter int BUFFER_DEPTH = 32,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  ssm_pkg::cls_t                 q_cls,
    input  logic signed [VALUE_WIDTH-1:0] q_value,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic signed [VALUE_WIDTH-1:0] value_res,
    output logic                          from_second,
    output logic                          run_last
);

    import ssm_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = CW + 1;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          owner_reg, owner_next;
    logic                          fe_reg, fe_next;
    logic                          se_reg, se_next;
    logic                          side_reg, side_next;
    logic                          is_end_reg, is_end_next;
    logic signed [VALUE_WIDTH-1:0] cur_reg, cur_next;

    logic                          ov_reg, ov_next;
    logic [1:0]                    kind_reg, kind_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                          fs_reg, fs_next;
    logic                          last_reg, last_next;

    logic                          wr_en;
    logic [AW-1:0]                 tail;
    logic [SW-1:0]                 tail_sum;
    logic signed [VALUE_WIDTH-1:0] rd_data;
    logic [AW-1:0]                 head_inc;
    logic                          can_emit;
    logic                          emit;
    logic [1:0]                    e_kind;
    logic signed [VALUE_WIDTH-1:0] e_val;
    logic                          e_fs;
    logic                          e_last;
    logic                          own_end;
    logic                          other_end;
    logic                          cnt_nz;
    logic                          cnt_one;
    logic                          full;
    logic                          head_wins;
    logic                          fe_upd;
    logic                          se_upd;

    ssm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data (cur_reg),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail      = (tail_sum >= SW'(BUFFER_DEPTH)) ? AW'(tail_sum - SW'(BUFFER_DEPTH))
                                                        : AW'(tail_sum);
    assign head_inc  = (head_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign own_end   = side_reg ? se_reg : fe_reg;
    assign other_end = side_reg ? fe_reg : se_reg;
    assign cnt_nz    = (count_reg != '0);
    assign cnt_one   = (count_reg == CW'(1));
    assign full      = (count_reg >= CW'(BUFFER_DEPTH));
    assign head_wins = (owner_reg == SIDE_FIRST) ? (rd_data <= cur_reg) : (rd_data < cur_reg);
    assign fe_upd    = fe_reg | (side_reg == SIDE_FIRST);
    assign se_upd    = se_reg | (side_reg == SIDE_SECOND);
    assign can_emit  = !ov_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        owner_next  = owner_reg;
        fe_next     = fe_reg;
        se_next     = se_reg;
        side_next   = side_reg;
        is_end_next = is_end_reg;
        cur_next    = cur_reg;
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        emit        = 1'b0;
        e_kind      = KIND_ELEM;
        e_val       = '0;
        e_fs        = 1'b0;
        e_last      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    side_next   = q_cls.side;
                    is_end_next = q_cls.is_end;
                    cur_next    = q_value;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (is_end_reg)
                begin
                    fe_next = fe_upd;
                    se_next = se_upd;
                    if (fe_upd && se_upd)
                    begin
                        state_next = cnt_nz ? ST_FLUSH_RD : ST_FINAL;
                    end
                    else if (cnt_nz && owner_reg != side_reg)
                    begin
                        state_next = ST_FLUSH_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (own_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_nz && owner_reg != side_reg)
                begin
                    state_next = ST_CMP_RD;
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (head_wins)
                    begin
                        e_val      = rd_data;
                        e_fs       = owner_reg;
                        e_last     = cnt_one && !other_end;
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                        state_next = cnt_one ? ST_TAIL : ST_CMP_RD;
                    end
                    else
                    begin
                        e_val      = cur_reg;
                        e_fs       = side_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (other_end)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        e_val      = cur_reg;
                        e_fs       = side_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (full)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_DROP;
                        e_fs       = side_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (!cnt_nz)
                    begin
                        owner_next = side_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_RD:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    e_val      = rd_data;
                    e_fs       = owner_reg;
                    e_last     = cnt_one && !(fe_reg && se_reg);
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    if (!cnt_one)
                    begin
                        state_next = ST_FLUSH_RD;
                    end
                    else if (fe_reg && se_reg)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINAL:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_END;
                    e_last     = 1'b1;
                    head_next  = '0;
                    count_next = '0;
                    owner_next = SIDE_FIRST;
                    fe_next    = 1'b0;
                    se_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next   = ov_reg && out_stall;
        kind_next = kind_reg;
        val_next  = val_reg;
        fs_next   = fs_reg;
        last_next = last_reg;
        if (emit)
        begin
            ov_next   = 1'b1;
            kind_next = e_kind;
            val_next  = e_val;
            fs_next   = e_fs;
            last_next = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            owner_reg <= SIDE_FIRST;
            fe_reg    <= 1'b0;
            se_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            owner_reg <= owner_next;
            fe_reg    <= fe_next;
            se_reg    <= se_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg   <= side_next;
        is_end_reg <= is_end_next;
        cur_reg    <= cur_next;
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        fs_reg     <= fs_next;
        last_reg   <= last_next;
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign value_res   = val_reg;
    assign from_second = fs_reg;
    assign run_last    = last_reg;

endmodule

>>> hw/rtl/sorted_stream_merge_top.sv
// An accepted item waits in the front queue; the back part pops it in ST_IDLE and
// decodes it in ST_DECODE, where an ignored element is dropped. An element is then
// buffered, passed through or dropped in ST_TAIL, or compared against each pending head
// in ST_CMP_RD and ST_CMP (registered read); ends flush in ST_FLUSH_RD and ST_FLUSH.
// Output stalls hold the back part; the front queue takes new items meanwhile, until full.
// Reset (rst_n, async) clears control state; the pending buffer RAM is not cleared.
module sorted_stream_merge_top #(
    parameter int BUFFER_DEPTH = 32,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic signed [VALUE_WIDTH-1:0] value_res,
    output logic                          from_second,
    output logic                          run_last
);

    import ssm_pkg::*;

    logic                          q_valid;
    cls_t                          q_cls;
    logic signed [VALUE_WIDTH-1:0] q_value;
    logic                          q_pop;

    ssm_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .value    (value),
        .q_valid  (q_valid),
        .q_cls    (q_cls),
        .q_value  (q_value),
        .q_pop    (q_pop)
    );

    ssm_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cls       (q_cls),
        .q_value     (q_value),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value_res   (value_res),
        .from_second (from_second),
        .run_last    (run_last)
    );

endmodule

>>> hw/rtl/ssm_checker.sv
// Port-level checker for sorted_stream_merge_top, bound to the top level.
// Depends on ssm_pkg and sorted_stream_merge_top_defines.svh.
`include "sorted_stream_merge_top_defines.svh"

module ssm_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    kind,
    input logic signed [VALUE_WIDTH-1:0] value_res,
    input logic                          from_second,
    input logic                          run_last
);

    import ssm_pkg::*;

    `SSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `SSM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(kind) && $stable(value_res))
    `SSM_ASSERT_NOW(a_end_fields, out_valid && kind == KIND_END, run_last && !from_second && value_res == '0)
    `SSM_ASSERT_NOW(a_drop_fields, out_valid && kind == KIND_DROP, run_last && value_res == '0)

endmodule

bind sorted_stream_merge_top ssm_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ssm_checker (.*);

>>> test/tb_sorted_stream_merge_top.sv
// Self-checking testbench for sorted_stream_merge_top: random and directed merge
// runs, per-result field checks against a behavioral merge predictor.
// Depends on ssm_pkg and sorted_stream_merge_top.
`timescale 1ns / 100ps

module tb_sorted_stream_merge_top;
    import ssm_pkg::*;

    localparam int DEPTH       = 32;
    localparam int VW          = 32;
    localparam int TOTAL_ITEMS = 320;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 120;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

    typedef struct {
        logic [1:0]           cmd;
        logic signed [VW-1:0] value;
        int                   gap;
        bit                   drain;
        bit                   hold;
    } merge_item_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [VW-1:0] value;
        logic                 side;
        logic                 last;
    } merge_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           cmd = CMD_FIRST;
    logic signed [VW-1:0] value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           kind;
    logic signed [VW-1:0] value_res;
    logic                 from_second;
    logic                 run_last;

    merge_item_t   stim_q[$];
    merge_result_t awaited[$];
    merge_result_t step_out[$];

    // merge predictor state
    logic signed [VW-1:0] pend_store [DEPTH];
    int                   pend_head = 0;
    int                   pend_count = 0;
    logic                 pend_owner = SIDE_FIRST;
    logic                 first_ended = 1'b0;
    logic                 second_ended = 1'b0;

    int   item_count = 0;
    bit   burst = 1'b0;
    int   taken_count = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    logic hold_start = 1'b0;
    int   send_gap = 0;
    bit   gap_armed = 1'b0;
    int   hold_left = 0;
    int   recv_gap = 0;
    int   recv_seen = 0;
    bit   recv_quiet = 1'b0;

    sorted_stream_merge_top #(
        .BUFFER_DEPTH(DEPTH),
        .VALUE_WIDTH (VW)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .value_res  (value_res),
        .from_second(from_second),
        .run_last   (run_last)
    );

    always #5 clk = ~clk;

    function automatic void emit(logic [1:0] k, logic signed [VW-1:0] v, logic s);
        merge_result_t r;
        r.kind  = k;
        r.value = v;
        r.side  = s;
        r.last  = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void release_head();
        emit(KIND_ELEM, pend_store[pend_head], pend_owner);
        pend_head = (pend_head + 1) % DEPTH;
        pend_count--;
    endfunction

    function automatic void merge_predict(logic [1:0] c, logic signed [VW-1:0] v);
        logic side;
        logic own_end;
        logic other_end;
        bit   placed;
        merge_result_t r;
        placed = 1'b0;
        step_out.delete();
        if (c == CMD_FIRST || c == CMD_SECOND) begin
            side      = (c == CMD_SECOND) ? SIDE_SECOND : SIDE_FIRST;
            own_end   = (side == SIDE_SECOND) ? second_ended : first_ended;
            other_end = (side == SIDE_SECOND) ? first_ended : second_ended;
            if (!own_end) begin
                if (pend_count > 0 && pend_owner != side) begin
                    // ties go to the first sequence
                    while (pend_count > 0 && ((pend_owner == SIDE_FIRST) ?
                           (pend_store[pend_head] <= v) : (pend_store[pend_head] < v)))
                        release_head();
                    if (pend_count > 0) begin
                        emit(KIND_ELEM, v, side);
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    if (other_end)
                        emit(KIND_ELEM, v, side);
                    else if (pend_count >= DEPTH)
                        emit(KIND_DROP, '0, side);
                    else begin
                        if (pend_count == 0)
                            pend_owner = side;
                        pend_store[(pend_head + pend_count) % DEPTH] = v;
                        pend_count++;
                    end
                end
            end
        end
        else begin
            side = (c == CMD_END_SECOND) ? SIDE_SECOND : SIDE_FIRST;
            if (side == SIDE_SECOND)
                second_ended = 1'b1;
            else
                first_ended = 1'b1;
            if (first_ended && second_ended) begin
                while (pend_count > 0)
                    release_head();
                emit(KIND_END, '0, SIDE_FIRST);
                pend_head    = 0;
                pend_count   = 0;
                pend_owner   = SIDE_FIRST;
                first_ended  = 1'b0;
                second_ended = 1'b0;
            end
            else if (pend_count > 0 && pend_owner != side) begin
                while (pend_count > 0)
                    release_head();
            end
        end
        if (step_out.size() != 0) begin
            r = step_out[step_out.size() - 1];
            r.last = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
        foreach (step_out[i])
            awaited.push_back(step_out[i]);
    endfunction

    function automatic void queue_item(logic [1:0] c, logic signed [VW-1:0] v);
        merge_item_t it;
        if (item_count % 40 == 0)
            burst = ($urandom_range(0, 2) == 0);
        it.cmd   = c;
        it.value = v;
        it.hold  = (item_count == HOLD_AT);
        it.drain = (item_count == 60 || item_count == 260);
        it.gap   = (burst || (item_count >= HOLD_AT && item_count < HOLD_AT + 60)) ?
                   0 : $urandom_range(0, 4);
        item_count++;
        stim_q.push_back(it);
    endfunction

    function automatic void check_field(string name, logic [VW-1:0] want_v,
                                        logic [VW-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h",
                     $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // one merge run: two ascending sequences interleaved, or a burst of noise
    task automatic add_run();
        int     mode;
        int     lop_side;
        int     s;
        int     len [2];
        int     pos [2];
        bit     done [2];
        bit     tight;
        longint start;
        longint cur;
        logic signed [VW-1:0] seqv [2][64];
        mode = $urandom_range(0, 7);
        if (mode == 0) begin
            repeat ($urandom_range(4, 12))
                queue_item(2'($urandom_range(0, 3)), $urandom);
            queue_item(CMD_END_FIRST, $urandom);
            queue_item(CMD_END_SECOND, $urandom);
        end
        else begin
            lop_side = $urandom_range(0, 1);
            tight    = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       start = longint'(VMIN);
                1:       start = longint'(VMAX) - $urandom_range(0, 20);
                default: start = longint'($signed($urandom));
            endcase
            for (int k = 0; k < 2; k++) begin
                if (mode == 1)
                    len[k] = (k == lop_side) ? $urandom_range(30, 40) : $urandom_range(1, 5);
                else
                    len[k] = $urandom_range(0, 12);
                pos[k]  = 0;
                done[k] = 1'b0;
                cur     = start;
                for (int j = 0; j < len[k]; j++) begin
                    seqv[k][j] = cur[VW-1:0];
                    cur += tight ? longint'($urandom_range(0, 2)) :
                                   (longint'($urandom) >> $urandom_range(4, 31));
                    if (cur > longint'(VMAX))
                        cur = longint'(VMAX);
                end
            end
            while (!(done[0] && done[1])) begin
                if (done[0])
                    s = 1;
                else if (done[1])
                    s = 0;
                else if (mode == 1)
                    s = (pos[lop_side] < len[lop_side]) ? lop_side : 1 - lop_side;
                else
                    s = $urandom_range(0, 1);
                if (pos[s] < len[s]) begin
                    queue_item((s == 1) ? CMD_SECOND : CMD_FIRST, seqv[s][pos[s]]);
                    pos[s]++;
                end
                else begin
                    queue_item((s == 1) ? CMD_END_SECOND : CMD_END_FIRST, $urandom);
                    done[s] = 1'b1;
                end
            end
        end
    endtask

    // driver
    always @(negedge clk) begin
        merge_item_t it;
        bit go;
        go = 1'b0;
        if (rst_n && !(in_valid && !in_took)) begin
            if (stim_q.size() != 0) begin
                if (!gap_armed) begin
                    send_gap  = stim_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (send_gap != 0)
                    send_gap--;
                else if (!stim_q[0].drain || awaited.size() == 0)
                    go = 1'b1;
            end
            if (go) begin
                it        = stim_q.pop_front();
                gap_armed = 1'b0;
                cmd   <= it.cmd;
                value <= it.value;
            end
            in_valid <= go;
        end
        hold_start <= go && it.hold;
    end

    // receiver
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_start)
                hold_left = HOLD_CYCLES;
            if (out_took) begin
                recv_seen++;
                if (recv_seen % 50 == 0)
                    recv_quiet = ($urandom_range(0, 2) == 0);
                recv_gap = recv_quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap != 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk) begin
        merge_result_t want;
        in_took  <= rst_n && in_valid && !in_stall;
        out_took <= rst_n && out_valid && !out_stall;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                merge_predict(cmd, value);
                taken_count++;
            end
            if (out_valid && !out_stall) begin
                if (awaited.size() == 0) begin
                    $display({"%0t ns: unexpected result, expected none, actual kind %0d",
                              " value 0x%h from_second %0b run_last %0b"},
                             $time, kind, value_res, from_second, run_last);
                    mismatch_count++;
                end
                else begin
                    want = awaited.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("value_res", want.value, value_res);
                    check_field("from_second", want.side, from_second);
                    check_field("run_last", want.last, run_last);
                end
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sorted_stream_merge_top");
            $finish;
        end
    end

    initial begin
        // directed: extremes, ties, ignored elements, repeated and early ends
        queue_item(CMD_FIRST, VMIN);
        queue_item(CMD_FIRST, -1);
        queue_item(CMD_SECOND, VMIN);
        queue_item(CMD_SECOND, 0);
        queue_item(CMD_FIRST, 0);
        queue_item(CMD_FIRST, VMAX);
        queue_item(CMD_END_SECOND, VMAX);
        queue_item(CMD_SECOND, 7);
        queue_item(CMD_END_SECOND, -1);
        queue_item(CMD_FIRST, 3);
        queue_item(CMD_END_FIRST, VMIN);
        queue_item(CMD_SECOND, 5);
        queue_item(CMD_FIRST, 5);
        queue_item(CMD_FIRST, 6);
        queue_item(CMD_END_FIRST, 0);
        queue_item(CMD_FIRST, 9);
        queue_item(CMD_SECOND, 6);
        queue_item(CMD_SECOND, VMAX);
        queue_item(CMD_END_SECOND, 0);
        while (item_count < TOTAL_ITEMS)
            add_run();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while (taken_count < item_count)
            @(negedge clk);
        while (awaited.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("PASS sorted_stream_merge_top");
        else
            $display("FAIL sorted_stream_merge_top");
        $finish;
    end

endmodule
